FILE: hw/rtl/mbgt_pkg.sv
// ----------------------------------------------------------------------------
// mbgt_pkg: shared types and constants of the mouse button gesture toggle
// Event and result payload structs, event codes and register reset values.
// ----------------------------------------------------------------------------
package mbgt_pkg;

	typedef struct packed {
		logic [4:0]         event_type;
		logic [9:0]         event_code;
		logic signed [31:0] event_value;
	} event_t;

	typedef struct packed {
		logic forward_event;
		logic meta_changed;
		logic meta_pressed;
		logic scroll_changed;
		logic scroll_pressed;
		logic overrun_reset;
	} result_t;

	// Gesture phases, one-hot.
	typedef enum logic [3:0] {
		PH_IDLE      = 4'b0001,
		PH_PENDING   = 4'b0010,
		PH_SCROLL_ON = 4'b0100,
		PH_SCROLL_EX = 4'b1000
	} phase_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		REG_MOTION_THRESHOLD = 1'b0,
		REG_BACK_SCAN_CODE   = 1'b1
	} reg_index_t;

	localparam logic [4:0]  TYPE_SYN = 5'd0;
	localparam logic [4:0]  TYPE_KEY = 5'd1;
	localparam logic [4:0]  TYPE_REL = 5'd2;
	localparam logic [4:0]  TYPE_MSC = 5'd4;

	localparam logic [9:0]  CODE_SYN_DROPPED = 10'd3;
	localparam logic [9:0]  CODE_REL_X       = 10'd0;
	localparam logic [9:0]  CODE_REL_Y       = 10'd1;
	localparam logic [9:0]  CODE_MSC_SCAN    = 10'd4;
	localparam logic [9:0]  CODE_BTN_SIDE    = 10'h113;

	localparam logic signed [31:0] VAL_PRESS   = 32'sd1;
	localparam logic signed [31:0] VAL_RELEASE = 32'sd0;

	localparam logic [13:0] MOTION_MAX          = 14'h3FFF;
	localparam logic [13:0] THRESHOLD_RESET     = 14'd12;
	localparam logic [31:0] BACK_SCAN_RESET     = 32'h0009_0004;

endpackage

FILE: hw/rtl/mouse_button_gesture_toggle.sv
// ----------------------------------------------------------------------------
// mouse_button_gesture_toggle: back-button gesture filter for mouse events
// Takes one input event per transaction and returns one result per event:
// whether the event is forwarded, and any meta or scroll button actions.
// A tap of the back button toggles a meta lock; holding it while moving far
// enough turns it into a scroll lock; a dropped-events sync clears all gesture state.
// The block accepts one event every clock cycle while the result side does
// not stall. An event passes an input register and then a result register
// that drives the result outputs; the gesture state is updated by one level
// of compare and saturating add logic between the two. Configuration writes
// are always ready and must be issued while no event is in flight.
// ----------------------------------------------------------------------------
module mouse_button_gesture_toggle (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                evt_valid,
	output logic                evt_stall,
	input  mbgt_pkg::event_t    evt,
	output logic                res_valid,
	input  logic                res_stall,
	output mbgt_pkg::result_t   res,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [0:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	// Configuration registers.
	logic [13:0] threshold_q;
	logic [31:0] back_scan_q;

	// Gesture state.
	mbgt_pkg::phase_t phase_q, phase_d;
	logic        meta_lock_q, meta_lock_d;
	logic        scroll_lock_q, scroll_lock_d;
	logic [13:0] motion_sum_q, motion_sum_d;
	logic        scan_back_q, scan_back_d;

	// Pipeline.
	logic              valid_s1, valid_s2;
	mbgt_pkg::event_t  evt_s1;
	mbgt_pkg::result_t res_s2, res_d;
	logic              adv_s2, adv_s1, accept;

	logic              is_drop;
	logic [31:0]       mag;
	logic [14:0]       sum_wide;
	logic [13:0]       sum_sat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= mbgt_pkg::THRESHOLD_RESET;
			back_scan_q <= mbgt_pkg::BACK_SCAN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (mbgt_pkg::reg_index_t'(cfg_index))
				mbgt_pkg::REG_MOTION_THRESHOLD: threshold_q <= cfg_data[13:0];
				mbgt_pkg::REG_BACK_SCAN_CODE:   back_scan_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// The result register frees up when empty or when its transaction leaves.
	assign adv_s2    = !valid_s2 || !res_stall;
	assign adv_s1    = valid_s1 && adv_s2;
	assign evt_stall = valid_s1 && !adv_s2;
	assign accept    = evt_valid && !evt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			evt_s1 <= evt;
		end
	end

	// Magnitude of a motion delta; the most negative value yields 2^31.
	assign mag      = evt_s1.event_value[31] ? (32'd0 - evt_s1.event_value)
		: evt_s1.event_value;
	assign sum_wide = {1'b0, motion_sum_q} + {1'b0, mag[13:0]};
	assign sum_sat  = ((|mag[31:14]) || sum_wide[14]) ? mbgt_pkg::MOTION_MAX
		: sum_wide[13:0];
	assign is_drop  = (evt_s1.event_type == mbgt_pkg::TYPE_SYN)
		&& (evt_s1.event_code == mbgt_pkg::CODE_SYN_DROPPED);

	always_comb begin
		phase_d       = phase_q;
		meta_lock_d   = meta_lock_q;
		scroll_lock_d = scroll_lock_q;
		motion_sum_d  = motion_sum_q;
		scan_back_d   = scan_back_q;
		res_d         = '0;
		res_d.forward_event = 1'b1;

		priority if (evt_s1.event_type == mbgt_pkg::TYPE_MSC) begin
			if (evt_s1.event_code == mbgt_pkg::CODE_MSC_SCAN) begin
				scan_back_d = (evt_s1.event_value == back_scan_q);
			end
			res_d.forward_event = 1'b0;
		end else if (is_drop) begin
			// Release whichever locks were held, then return to reset state.
			res_d.meta_changed   = meta_lock_q;
			res_d.scroll_changed = scroll_lock_q;
			res_d.overrun_reset  = 1'b1;
			res_d.forward_event  = 1'b0;
			phase_d       = mbgt_pkg::PH_IDLE;
			meta_lock_d   = 1'b0;
			scroll_lock_d = 1'b0;
			motion_sum_d  = '0;
			scan_back_d   = 1'b0;
		end else if (evt_s1.event_type == mbgt_pkg::TYPE_KEY) begin
			scan_back_d = 1'b0;
			if ((evt_s1.event_code == mbgt_pkg::CODE_BTN_SIDE) || scan_back_q) begin
				res_d.forward_event = 1'b0;
				if (evt_s1.event_value == mbgt_pkg::VAL_PRESS) begin
					motion_sum_d = '0;
					if (scroll_lock_q) begin
						scroll_lock_d        = 1'b0;
						phase_d              = mbgt_pkg::PH_SCROLL_EX;
						res_d.scroll_changed = 1'b1;
					end else begin
						phase_d = mbgt_pkg::PH_PENDING;
					end
				end else if (evt_s1.event_value == mbgt_pkg::VAL_RELEASE) begin
					if (phase_q == mbgt_pkg::PH_PENDING) begin
						meta_lock_d        = !meta_lock_q;
						res_d.meta_changed = 1'b1;
						res_d.meta_pressed = !meta_lock_q;
					end
					phase_d      = mbgt_pkg::PH_IDLE;
					motion_sum_d = '0;
				end
			end
		end else if (evt_s1.event_type == mbgt_pkg::TYPE_REL) begin
			if (((evt_s1.event_code == mbgt_pkg::CODE_REL_X)
					|| (evt_s1.event_code == mbgt_pkg::CODE_REL_Y))
					&& (phase_q == mbgt_pkg::PH_PENDING)) begin
				motion_sum_d = sum_sat;
				if (sum_sat >= threshold_q) begin
					if (meta_lock_q) begin
						meta_lock_d        = 1'b0;
						res_d.meta_changed = 1'b1;
					end
					scroll_lock_d        = 1'b1;
					phase_d              = mbgt_pkg::PH_SCROLL_ON;
					res_d.scroll_changed = 1'b1;
					res_d.scroll_pressed = 1'b1;
				end
			end
		end else if (evt_s1.event_type == mbgt_pkg::TYPE_SYN) begin
			scan_back_d = 1'b0;
		end else begin
			// Unknown types pass through untouched.
			res_d.forward_event = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= mbgt_pkg::PH_IDLE;
			meta_lock_q   <= 1'b0;
			scroll_lock_q <= 1'b0;
			motion_sum_q  <= '0;
			scan_back_q   <= 1'b0;
		end else if (adv_s1) begin
			phase_q       <= phase_d;
			meta_lock_q   <= meta_lock_d;
			scroll_lock_q <= scroll_lock_d;
			motion_sum_q  <= motion_sum_d;
			scan_back_q   <= scan_back_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_d;
		end
	end

	assign res_valid = valid_s2;
	assign res       = res_s2;

	// A dropped-events sync leaves every piece of gesture state cleared.
	a_drop_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && is_drop |=> (phase_q == mbgt_pkg::PH_IDLE) && !meta_lock_q
			&& !scroll_lock_q && (motion_sum_q == 14'd0) && !scan_back_q)
		else $error("gesture state not cleared after dropped sync");

	// Entering scroll always drops the meta lock.
	a_scroll_drops_meta: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(scroll_lock_q) |-> !meta_lock_q && (phase_q == mbgt_pkg::PH_SCROLL_ON))
		else $error("scroll lock entered with meta held or wrong phase");

	// A press value is only reported together with its action.
	a_press_needs_change: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (!res_s2.meta_pressed || res_s2.meta_changed)
			&& (!res_s2.scroll_pressed || res_s2.scroll_changed))
		else $error("press value without action");

	// An overrun result is never forwarded and never presses anything.
	a_overrun_result: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.overrun_reset |-> !res_s2.forward_event
			&& !res_s2.meta_pressed && !res_s2.scroll_pressed)
		else $error("malformed overrun result");

endmodule

FILE: bench/tb_mouse_button_gesture_toggle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mouse_button_gesture_toggle: self-checking bench for the gesture filter
// A directed table of events is followed by random back-button gestures under
// several register settings, with random gaps on the event side and random
// stalls on the result side. Every accepted event is run through a behavioral
// model of the filter, and each result transaction is compared field by field
// with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_mouse_button_gesture_toggle;

	localparam int ITEMS_PER_PHASE = 210;
	localparam int NUM_PHASES      = 6;
	localparam int HOLD_CYCLES     = 120;

	localparam logic [4:0] TYPE_ABS        = 5'd3;
	localparam logic [9:0] CODE_SYN_REPORT = 10'd0;
	localparam logic [9:0] CODE_BTN_LEFT   = 10'h110;
	localparam logic [9:0] CODE_REL_WHEEL  = 10'd8;

	typedef struct {
		mbgt_pkg::event_t  ev;
		bit                pinned;
		mbgt_pkg::result_t want;
	} table_row_t;

	logic              clk;
	logic              arst_n;
	logic              evt_valid;
	logic              evt_stall;
	mbgt_pkg::event_t  evt;
	logic              res_valid;
	logic              res_stall;
	mbgt_pkg::result_t res;
	logic              cfg_valid;
	logic              cfg_ready;
	logic [0:0]        cfg_index;
	logic [31:0]       cfg_data;

	// Travel with the event payload: a result typed into the directed table.
	bit                row_pinned;
	mbgt_pkg::result_t row_want;

	// Gesture state of the filter model and its copy of the registers.
	mbgt_pkg::phase_t  gst_phase;
	bit                gst_meta_lock;
	bit                gst_scroll_lock;
	bit                gst_scan_back;
	logic [13:0]       gst_motion;
	logic [13:0]       reg_threshold;
	logic [31:0]       reg_scan_code;

	mbgt_pkg::result_t expected_results[$];
	mbgt_pkg::result_t predicted;
	mbgt_pkg::result_t oldest;
	int                error_count;
	int                events_sent;
	bit                steady;
	bit                hold_rx;

	string field_name [6] = '{"overrun_reset", "scroll_pressed", "scroll_changed",
		"meta_pressed", "meta_changed", "forward_event"};

	table_row_t directed_rows [25] = '{
		'{'{mbgt_pkg::TYPE_SYN, CODE_SYN_REPORT, 32'sd0}, 1'b1, 6'b100000},
		'{'{mbgt_pkg::TYPE_KEY, mbgt_pkg::CODE_BTN_SIDE, mbgt_pkg::VAL_PRESS},
			1'b1, 6'b000000},
		'{'{mbgt_pkg::TYPE_KEY, mbgt_pkg::CODE_BTN_SIDE, mbgt_pkg::VAL_RELEASE},
			1'b1, 6'b011000},
		'{'{mbgt_pkg::TYPE_MSC, mbgt_pkg::CODE_MSC_SCAN, mbgt_pkg::BACK_SCAN_RESET},
			1'b1, 6'b000000},
		'{'{mbgt_pkg::TYPE_KEY, CODE_BTN_LEFT, mbgt_pkg::VAL_PRESS}, 1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_REL, mbgt_pkg::CODE_REL_X, 32'sd5}, 1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_REL, mbgt_pkg::CODE_REL_Y, -32'sd7}, 1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_KEY, mbgt_pkg::CODE_BTN_SIDE, mbgt_pkg::VAL_RELEASE},
			1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_KEY, mbgt_pkg::CODE_BTN_SIDE, mbgt_pkg::VAL_PRESS},
			1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_KEY, mbgt_pkg::CODE_BTN_SIDE, mbgt_pkg::VAL_RELEASE},
			1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_KEY, mbgt_pkg::CODE_BTN_SIDE, 32'sd2}, 1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_MSC, mbgt_pkg::CODE_MSC_SCAN, mbgt_pkg::BACK_SCAN_RESET},
			1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_SYN, CODE_SYN_REPORT, 32'sd0}, 1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_KEY, CODE_BTN_LEFT, mbgt_pkg::VAL_PRESS}, 1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_MSC, 10'd5, mbgt_pkg::BACK_SCAN_RESET}, 1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_KEY, mbgt_pkg::CODE_BTN_SIDE, mbgt_pkg::VAL_PRESS},
			1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_REL, mbgt_pkg::CODE_REL_X, 32'sh8000_0000}, 1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_REL, mbgt_pkg::CODE_REL_Y, 32'sh7FFF_FFFF}, 1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_SYN, mbgt_pkg::CODE_SYN_DROPPED, 32'sd0}, 1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_SYN, mbgt_pkg::CODE_SYN_DROPPED, 32'sd0}, 1'b1, 6'b000001},
		'{'{5'd31, 10'd1023, -32'sd1}, 1'b1, 6'b100000},
		'{'{mbgt_pkg::TYPE_REL, CODE_REL_WHEEL, 32'sd3}, 1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_KEY, mbgt_pkg::CODE_BTN_SIDE, mbgt_pkg::VAL_PRESS},
			1'b0, 6'b000000},
		'{'{mbgt_pkg::TYPE_REL, mbgt_pkg::CODE_REL_X, 32'sd11}, 1'b0, 6'b000000},
		'{'{TYPE_ABS, mbgt_pkg::CODE_REL_X, -32'sd1}, 1'b0, 6'b000000}
	};

	mouse_button_gesture_toggle u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_gesture();
		gst_phase       = mbgt_pkg::PH_IDLE;
		gst_meta_lock   = 1'b0;
		gst_scroll_lock = 1'b0;
		gst_motion      = '0;
		gst_scan_back   = 1'b0;
	endfunction

	// Classifies one event, updates the gesture state and returns its result.
	function automatic mbgt_pkg::result_t filter_event(mbgt_pkg::event_t ev);
		mbgt_pkg::result_t r;
		logic [31:0]       v;
		logic [31:0]       mag;
		bit                is_back;
		r = '0;
		r.forward_event = 1'b1;
		v = ev.event_value;
		if (ev.event_type == mbgt_pkg::TYPE_MSC) begin
			if (ev.event_code == mbgt_pkg::CODE_MSC_SCAN)
				gst_scan_back = (v == reg_scan_code);
			r.forward_event = 1'b0;
		end else if (ev.event_type == mbgt_pkg::TYPE_SYN
				&& ev.event_code == mbgt_pkg::CODE_SYN_DROPPED) begin
			r.meta_changed   = gst_meta_lock;
			r.scroll_changed = gst_scroll_lock;
			r.overrun_reset  = 1'b1;
			r.forward_event  = 1'b0;
			clear_gesture();
		end else if (ev.event_type == mbgt_pkg::TYPE_KEY) begin
			is_back = (ev.event_code == mbgt_pkg::CODE_BTN_SIDE) || gst_scan_back;
			gst_scan_back = 1'b0;
			if (is_back) begin
				r.forward_event = 1'b0;
				if (ev.event_value == mbgt_pkg::VAL_PRESS) begin
					gst_motion = '0;
					if (gst_scroll_lock) begin
						gst_scroll_lock  = 1'b0;
						gst_phase        = mbgt_pkg::PH_SCROLL_EX;
						r.scroll_changed = 1'b1;
					end else begin
						gst_phase = mbgt_pkg::PH_PENDING;
					end
				end else if (ev.event_value == mbgt_pkg::VAL_RELEASE) begin
					if (gst_phase == mbgt_pkg::PH_PENDING) begin
						gst_meta_lock  = !gst_meta_lock;
						r.meta_changed = 1'b1;
						r.meta_pressed = gst_meta_lock;
					end
					gst_phase  = mbgt_pkg::PH_IDLE;
					gst_motion = '0;
				end
			end
		end else if (ev.event_type == mbgt_pkg::TYPE_REL) begin
			if ((ev.event_code == mbgt_pkg::CODE_REL_X || ev.event_code == mbgt_pkg::CODE_REL_Y)
					&& gst_phase == mbgt_pkg::PH_PENDING) begin
				// The most negative delta has a magnitude of 2^31.
				mag = v[31] ? -v : v;
				if (mag > {18'd0, mbgt_pkg::MOTION_MAX} - {18'd0, gst_motion})
					gst_motion = mbgt_pkg::MOTION_MAX;
				else
					gst_motion = gst_motion + mag[13:0];
				if (gst_motion >= reg_threshold) begin
					if (gst_meta_lock) begin
						gst_meta_lock  = 1'b0;
						r.meta_changed = 1'b1;
					end
					gst_scroll_lock  = 1'b1;
					gst_phase        = mbgt_pkg::PH_SCROLL_ON;
					r.scroll_changed = 1'b1;
					r.scroll_pressed = 1'b1;
				end
			end
		end else if (ev.event_type == mbgt_pkg::TYPE_SYN) begin
			gst_scan_back = 1'b0;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == mbgt_pkg::REG_MOTION_THRESHOLD)
					reg_threshold = cfg_data[13:0];
				else
					reg_scan_code = cfg_data;
			end
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					error_count++;
					$display("%0t ns: result %b with none expected", $time, res);
				end else begin
					oldest = expected_results.pop_front();
					if (res !== oldest) begin
						error_count++;
						for (int i = 5; i >= 0; i--) begin
							if (res[i] !== oldest[i])
								$display("%0t ns: %s expected %b, got %b", $time,
									field_name[i], oldest[i], res[i]);
						end
					end
				end
			end
			if (evt_valid && !evt_stall) begin
				predicted = filter_event(evt);
				expected_results.push_back(row_pinned ? row_want : predicted);
			end
		end
	end

	// Result side: short random stalls, now and then a long one, and a single
	// long hold-off on request so that the filter backs up into its input.
	initial begin
		int n;
		res_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_rx) begin
				res_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				res_stall <= 1'b0;
				hold_rx = 1'b0;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				n = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	function automatic mbgt_pkg::event_t mk_event(logic [4:0] t, logic [9:0] c,
		logic signed [31:0] v);
		mbgt_pkg::event_t ev;
		ev.event_type  = t;
		ev.event_code  = c;
		ev.event_value = v;
		return ev;
	endfunction

	function automatic mbgt_pkg::event_t noise_event();
		logic [31:0] rnd;
		rnd = $urandom;
		return mk_event(rnd[4:0], rnd[14:5], $urandom);
	endfunction

	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 31);
		if (r < 18)
			return 0;
		else if (r < 29)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Offers one event and returns at the edge where it is accepted, with
	// valid still high so that the next transaction can follow back to back.
	task automatic send_event(mbgt_pkg::event_t ev, bit pinned, mbgt_pkg::result_t want);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			evt_valid <= 1'b0;
			evt <= noise_event();
			repeat (gap) @(posedge clk);
		end
		evt_valid  <= 1'b1;
		evt        <= ev;
		row_pinned <= pinned;
		row_want   <= want;
		do @(posedge clk); while (evt_stall);
		events_sent++;
	endtask

	task automatic send_plain(logic [4:0] t, logic [9:0] c, logic signed [31:0] v);
		send_event(mk_event(t, c, v), 1'b0, '0);
	endtask

	// A back key arrives either as the side button or as a scan event that
	// marks the key event right after it.
	task automatic back_key(logic signed [31:0] v);
		logic [31:0] rnd;
		rnd = $urandom;
		if (rnd[1:0] == 2'd0) begin
			send_plain(mbgt_pkg::TYPE_MSC, mbgt_pkg::CODE_MSC_SCAN, reg_scan_code);
			send_plain(mbgt_pkg::TYPE_KEY, rnd[11:2], v);
		end else begin
			send_plain(mbgt_pkg::TYPE_KEY, mbgt_pkg::CODE_BTN_SIDE, v);
		end
	endtask

	task automatic send_motion(bit far);
		int unsigned        m;
		logic signed [31:0] d;
		m = far ? $urandom_range(0, reg_threshold / 2 + 1) : $urandom_range(0, reg_threshold / 4);
		d = $urandom_range(0, 1) ? -m : m;
		send_plain(mbgt_pkg::TYPE_REL,
			$urandom_range(0, 1) ? mbgt_pkg::CODE_REL_Y : mbgt_pkg::CODE_REL_X, d);
	endtask

	task automatic play_gesture();
		int          kind;
		int          n;
		logic [31:0] rnd;
		kind = $urandom_range(0, 99);
		rnd  = $urandom;
		if (kind < 55) begin
			// Taps stay below a nonzero threshold; drags usually cross it.
			back_key(mbgt_pkg::VAL_PRESS);
			n = (kind < 25) ? $urandom_range(0, 2) : $urandom_range(1, 10);
			repeat (n) begin
				if ($urandom_range(0, 3) == 0)
					send_plain(mbgt_pkg::TYPE_SYN, CODE_SYN_REPORT, 32'sd0);
				else
					send_motion(kind >= 25);
			end
			if ($urandom_range(0, 15) != 0)
				back_key(mbgt_pkg::VAL_RELEASE);
		end else if (kind < 65) begin
			back_key(mbgt_pkg::VAL_PRESS);
			back_key(mbgt_pkg::VAL_RELEASE);
		end else if (kind < 71) begin
			send_plain(mbgt_pkg::TYPE_SYN, mbgt_pkg::CODE_SYN_DROPPED, rnd);
		end else if (kind < 77) begin
			back_key(rnd);
		end else if (kind < 84) begin
			send_plain(mbgt_pkg::TYPE_REL,
				rnd[0] ? mbgt_pkg::CODE_REL_Y : mbgt_pkg::CODE_REL_X, $urandom);
		end else if (kind < 91) begin
			send_plain(mbgt_pkg::TYPE_MSC, rnd[1] ? mbgt_pkg::CODE_MSC_SCAN : rnd[11:2],
				rnd[12] ? reg_scan_code : $urandom);
			send_plain(rnd[13] ? mbgt_pkg::TYPE_KEY : rnd[18:14], rnd[28:19],
				rnd[29] ? mbgt_pkg::VAL_PRESS : mbgt_pkg::VAL_RELEASE);
		end else begin
			send_event(noise_event(), 1'b0, '0);
		end
	endtask

	// Stops offering events and waits until every expected result has come.
	task automatic drain_results();
		evt_valid <= 1'b0;
		do @(posedge clk); while (expected_results.size() != 0);
	endtask

	task automatic write_registers(logic [31:0] thr_word, logic [31:0] scan);
		drain_results();
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= mbgt_pkg::REG_MOTION_THRESHOLD;
		cfg_data  <= thr_word;
		do @(posedge clk); while (!cfg_ready);
		cfg_index <= mbgt_pkg::REG_BACK_SCAN_CODE;
		cfg_data  <= scan;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int          start;
		int          waited;
		bit          drained;
		logic [31:0] rnd;
		logic [31:0] thr;
		arst_n      = 1'b0;
		evt_valid   = 1'b0;
		evt         = '0;
		row_pinned  = 1'b0;
		row_want    = '0;
		cfg_valid   = 1'b0;
		cfg_index   = mbgt_pkg::REG_MOTION_THRESHOLD;
		cfg_data    = '0;
		steady      = 1'b0;
		hold_rx     = 1'b0;
		error_count = 0;
		events_sent = 0;
		drained     = 1'b0;
		reg_threshold = mbgt_pkg::THRESHOLD_RESET;
		reg_scan_code = mbgt_pkg::BACK_SCAN_RESET;
		clear_gesture();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[i])
			send_event(directed_rows[i].ev, directed_rows[i].pinned, directed_rows[i].want);

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			rnd = $urandom;
			thr = $urandom_range(1, 10000);
			case (ph)
				1: write_registers(32'd0, 32'd0);
				2: write_registers(32'd1, 32'hFFFF_FFFF);
				3: write_registers(32'd10000, $urandom);
				4: write_registers({rnd[31:14], thr[13:0]}, $urandom);
				5: write_registers({rnd[31:14], mbgt_pkg::THRESHOLD_RESET},
					mbgt_pkg::BACK_SCAN_RESET);
				default: ;
			endcase
			steady = (ph == 2);
			if (ph == 1)
				hold_rx = 1'b1;
			start = events_sent;
			while (events_sent - start < ITEMS_PER_PHASE) begin
				play_gesture();
				if (ph == 3 && !drained && events_sent - start >= 100) begin
					drain_results();
					drained = 1'b1;
				end
			end
		end

		evt_valid <= 1'b0;
		waited = 0;
		while (expected_results.size() != 0 && waited < 20000) begin
			@(posedge clk);
			waited++;
		end
		repeat (10) @(posedge clk);
		if (expected_results.size() != 0) begin
			error_count++;
			$display("%0t ns: %0d expected results never arrived", $time,
				expected_results.size());
		end
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("%0t ns: timeout", $time);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: sim.f
hw/rtl/mbgt_pkg.sv
hw/rtl/mouse_button_gesture_toggle.sv
bench/tb_mouse_button_gesture_toggle.sv
